>>> hw/rtl/mac_learning_forward_table_core_defines.svh
// assertion macros for the rtl, included by mlft_back
`ifndef MAC_LEARNING_FORWARD_TABLE_CORE_DEFINES_SVH
`define MAC_LEARNING_FORWARD_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// plain property, checked at every rising clock edge outside reset
`define MLFT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// overlapping implication
`define MLFT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MLFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MLFT_ASSERT(lbl, clk, rstn, prop)
`define MLFT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MLFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/mlft_pkg.sv
package mlft_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int NUM_PEERS_DEF   = 8;

    localparam int MAC_W       = 48;
    localparam int PEER_ID_W   = 3;
    localparam int OPCODE_W    = 2;
    localparam int ACTION_W    = 3;
    localparam int PEER_MASK_W = 8;

    localparam logic [MAC_W-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOCAL_FRAME = 2'd0,
        OP_PEER_FRAME  = 2'd1,
        OP_PEER_CONN   = 2'd2,
        OP_PEER_REMOVE = 2'd3
    } opcode_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_DROP_UNKNOWN = 3'd0,
        ACT_DROP_LOCAL   = 3'd1,
        ACT_TO_PEERS     = 3'd2,
        ACT_LOCAL_NET    = 3'd3,
        ACT_EVENT_DONE   = 3'd4,
        ACT_DROP_ABSENT  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_LAST,
        BK_RESOLVE,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [MAC_W-1:0]     src_mac;
        logic [MAC_W-1:0]     dst_mac;
        logic [PEER_ID_W-1:0] peer_id;
    } in_item_t;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [PEER_MASK_W-1:0] peer_mask;
        logic                   learned;
        logic                   table_full;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        opcode_t              op;
        logic                 do_learn;
        logic                 is_bcast;
        logic                 peer_ok;
        logic [MAC_W-1:0]     src_mac;
        logic [MAC_W-1:0]     dst_mac;
        logic [PEER_ID_W-1:0] peer_id;
    } cmd_t;

endpackage

>>> hw/rtl/mlft_front.sv
module mlft_front #(
    parameter int NUM_PEERS = mlft_pkg::NUM_PEERS_DEF
) (
    input  logic             s_valid,
    output logic             s_ready,
    input  mlft_pkg::in_item_t s_item,
    input  logic             q_full,
    output logic             q_push,
    output mlft_pkg::cmd_t   q_item
);
    import mlft_pkg::*;

    logic peer_ok;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // peer ids at or above the peer count are not real peers
    assign peer_ok = {29'd0, s_item.peer_id} < 32'(NUM_PEERS);

    always_comb begin
        q_item.op       = opcode_t'(s_item.opcode);
        q_item.peer_ok  = peer_ok;
        q_item.is_bcast = (s_item.dst_mac == BCAST_MAC);
        q_item.do_learn = (s_item.opcode == OP_LOCAL_FRAME)
                        || ((s_item.opcode == OP_PEER_FRAME) && peer_ok);
        q_item.src_mac  = s_item.src_mac;
        q_item.dst_mac  = s_item.dst_mac;
        q_item.peer_id  = s_item.peer_id;
    end

endmodule

>>> hw/rtl/mlft_queue.sv
module mlft_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mlft_pkg::cmd_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output mlft_pkg::cmd_t pop_item
);
    import mlft_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign pop_valid = (fill_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/mlft_back.sv
`include "mac_learning_forward_table_core_defines.svh"

module mlft_back #(
    parameter int TABLE_DEPTH = mlft_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_PEERS   = mlft_pkg::NUM_PEERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  mlft_pkg::cmd_t      q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output mlft_pkg::out_item_t m_item
);
    import mlft_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LOC_W  = $clog2(NUM_PEERS + 1);

    localparam logic [LOC_W-1:0]     LOC_LOCAL = LOC_W'(NUM_PEERS);
    localparam logic [NUM_PEERS-1:0] PEER_ONE  = NUM_PEERS'(1);
    localparam logic [CNT_W-1:0]     CNT_FULL  = CNT_W'(TABLE_DEPTH);

    // table storage
    logic [MAC_W-1:0] mac_mem [TABLE_DEPTH];
    logic [LOC_W-1:0] loc_mem [TABLE_DEPTH];

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_PEERS-1:0] present_reg, present_next;
    logic                 src_hit_reg, src_hit_next;
    logic [LOC_W-1:0]     src_loc_reg, src_loc_next;
    logic                 dst_hit_reg, dst_hit_next;
    logic [LOC_W-1:0]     dst_loc_reg, dst_loc_next;
    logic                 rd_vld_reg;
    logic [MAC_W-1:0]     rd_mac_reg;
    logic [LOC_W-1:0]     rd_loc_reg;
    out_item_t            res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;

    logic [CNT_W-1:0]     count_m1;
    logic [ADDR_W-1:0]    last_idx;
    logic                 is_event;
    logic                 out_free;
    logic                 need_learn;
    logic                 is_full;
    logic                 mem_we;
    logic [LOC_W-1:0]     learn_loc;
    out_item_t            res_calc;

    assign count_m1 = count_reg - CNT_W'(1);
    assign last_idx = count_m1[ADDR_W-1:0];
    assign is_event = (q_item.op == OP_PEER_CONN) || (q_item.op == OP_PEER_REMOVE);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    if (is_event) begin
                        state_next = BK_OUT;
                    end else if (count_reg == '0) begin
                        state_next = BK_RESOLVE;
                    end else begin
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_SCAN: begin
                if (idx_reg == last_idx) begin
                    state_next = BK_LAST;
                end
            end
            BK_LAST:    state_next = BK_RESOLVE;
            BK_RESOLVE: state_next = BK_OUT;
            BK_OUT: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default:    state_next = BK_IDLE;
        endcase
    end

    // learn decision and forwarding result
    always_comb begin
        logic                   self_hit;
        logic                   d_found;
        logic [LOC_W-1:0]       d_loc;
        logic [PEER_MASK_W-1:0] present8;
        logic [PEER_MASK_W-1:0] excl;
        logic [NUM_PEERS-1:0]   present_sh;

        need_learn = cmd_reg.do_learn && !src_hit_reg;
        is_full    = (count_reg == CNT_FULL);
        mem_we     = (state_reg == BK_RESOLVE) && need_learn && !is_full;
        learn_loc  = (cmd_reg.op == OP_PEER_FRAME) ? LOC_W'(cmd_reg.peer_id) : LOC_LOCAL;

        // dst equal to a source learned right now counts as found, at the learned place
        self_hit   = !dst_hit_reg && mem_we && (cmd_reg.dst_mac == cmd_reg.src_mac);
        d_found    = dst_hit_reg || self_hit;
        d_loc      = dst_hit_reg ? dst_loc_reg : learn_loc;
        present8   = PEER_MASK_W'(present_reg);
        excl       = (src_hit_reg && (src_loc_reg < LOC_LOCAL))
                   ? (PEER_MASK_W'(1) << src_loc_reg) : '0;
        present_sh = present_reg >> d_loc;

        res_calc.action     = ACT_LOCAL_NET;
        res_calc.peer_mask  = '0;
        res_calc.learned    = mem_we;
        res_calc.table_full = need_learn && is_full;

        priority if (cmd_reg.op == OP_PEER_FRAME) begin
            res_calc.action = ACT_LOCAL_NET;
        end else if (cmd_reg.is_bcast) begin
            res_calc.action    = ACT_TO_PEERS;
            res_calc.peer_mask = present8 & ~excl;
        end else if (!d_found) begin
            res_calc.action = ACT_DROP_UNKNOWN;
        end else if (d_loc >= LOC_LOCAL) begin
            res_calc.action = ACT_DROP_LOCAL;
        end else if (present_sh[0]) begin
            res_calc.action    = ACT_TO_PEERS;
            res_calc.peer_mask = PEER_MASK_W'(1) << d_loc;
        end else begin
            res_calc.action = ACT_DROP_ABSENT;
        end
    end

    // datapath outputs per state
    always_comb begin
        q_pop        = (state_reg == BK_IDLE) && q_valid;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        present_next = present_reg;
        src_hit_next = src_hit_reg;
        src_loc_next = src_loc_reg;
        dst_hit_next = dst_hit_reg;
        dst_loc_next = dst_loc_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // compare the entry read in the previous cycle
        if (rd_vld_reg) begin
            if (!src_hit_reg && (rd_mac_reg == cmd_reg.src_mac)) begin
                src_hit_next = 1'b1;
                src_loc_next = rd_loc_reg;
            end
            if (!dst_hit_reg && (rd_mac_reg == cmd_reg.dst_mac)) begin
                dst_hit_next = 1'b1;
                dst_loc_next = rd_loc_reg;
            end
        end

        unique case (state_reg)
            BK_IDLE: begin
                if (q_pop) begin
                    cmd_next     = q_item;
                    idx_next     = '0;
                    src_hit_next = 1'b0;
                    dst_hit_next = 1'b0;
                    res_next.action     = ACT_EVENT_DONE;
                    res_next.peer_mask  = '0;
                    res_next.learned    = 1'b0;
                    res_next.table_full = 1'b0;
                    if (q_item.peer_ok && (q_item.op == OP_PEER_CONN)) begin
                        present_next = present_reg | (PEER_ONE << q_item.peer_id);
                    end else if (q_item.peer_ok && (q_item.op == OP_PEER_REMOVE)) begin
                        present_next = present_reg & ~(PEER_ONE << q_item.peer_id);
                    end
                end
            end
            BK_SCAN: begin
                idx_next = idx_reg + ADDR_W'(1);
            end
            BK_LAST: begin
            end
            BK_RESOLVE: begin
                res_next = res_calc;
                if (mem_we) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            present_reg <= '0;
            src_hit_reg <= 1'b0;
            dst_hit_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            present_reg <= present_next;
            src_hit_reg <= src_hit_next;
            dst_hit_reg <= dst_hit_next;
            rd_vld_reg  <= (state_reg == BK_SCAN);
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        src_loc_reg <= src_loc_next;
        dst_loc_reg <= dst_loc_next;
        res_reg     <= res_next;
        m_item_reg  <= m_item_next;
    end

    // one write port at the fill count, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mac_mem[count_reg[ADDR_W-1:0]] <= cmd_reg.src_mac;
            loc_mem[count_reg[ADDR_W-1:0]] <= learn_loc;
        end
        rd_mac_reg <= mac_mem[idx_reg];
        rd_loc_reg <= loc_mem[idx_reg];
    end

    `MLFT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_FULL)
    `MLFT_ASSERT_NEXT(a_learn_counts, aclk, aresetn, mem_we, count_reg == $past(count_reg) + CNT_W'(1))
    `MLFT_ASSERT_IMPL(a_learn_or_full, aclk, aresetn, state_reg == BK_OUT, !(res_reg.learned && res_reg.table_full))
    `MLFT_ASSERT_IMPL(a_mask_only_fwd, aclk, aresetn, m_valid_reg, (m_item_reg.action == ACT_TO_PEERS) || (m_item_reg.peer_mask == '0))

endmodule

>>> hw/rtl/mac_learning_forward_table_core.sv
// learning bridge table between a local segment and up to NUM_PEERS tunnel peers.
// each item is a frame header (opcode 0 local, 1 from peer) or a peer connect (2) or
// remove (3) event, and gives exactly one result item. sources are learned at their
// first-seen place into the lowest free slot and never move; a full table raises
// table_full and the frame is still forwarded. entries are searched one per cycle
// through a single registered memory read port, so a frame's time in the back
// end grows with the number of learned entries, while an event skips the search;
// the search loop over learned entries sets the rate. the table has no clearing
// pass after reset: slots fill in order and a fill count marks which are valid.
// the front classifies items into a two-entry queue, and a result register lets
// a new item enter while a result waits.
module mac_learning_forward_table_core #(
    parameter int TABLE_DEPTH = mlft_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_PEERS   = mlft_pkg::NUM_PEERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mlft_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output mlft_pkg::out_item_t m_item
);
    import mlft_pkg::*;

    // front to queue
    logic q_full;
    logic q_push;
    cmd_t q_push_item;

    // queue to back
    logic q_valid;
    logic q_pop;
    cmd_t q_item;

    // decode opcode, broadcast and peer range check
    mlft_front #(
        .NUM_PEERS (NUM_PEERS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_push_item)
    );

    // two-entry decoupling queue
    mlft_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    // table search, learning, peer presence and result register
    mlft_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUM_PEERS   (NUM_PEERS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

>>> bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlft_pkg::*;

    localparam int FDB_DEPTH   = TABLE_DEPTH_DEF;
    localparam int PEER_COUNT  = NUM_PEERS_DEF;
    localparam logic [3:0] LOC_LOCAL = 4'(PEER_COUNT);
    localparam int RANDOM_ITEMS = 1680;
    localparam int MAC_POOL_SIZE = 96;
    localparam int STALL_LIMIT  = 2000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_CAP   = 200;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    mac_learning_forward_table_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // forwarding database mirror
    // ------------------------------------------------------------------
    bit              fdb_valid [FDB_DEPTH];
    logic [MAC_W-1:0] fdb_mac  [FDB_DEPTH];
    logic [3:0]      fdb_loc   [FDB_DEPTH];
    logic [PEER_MASK_W-1:0] peers_up = '0;
    int              fdb_count = 0;

    in_item_t  frames_to_send [$];   // stimulus not yet offered to the dut
    out_item_t fwd_expect     [$];   // forwarding decisions still owed by the dut
    logic [MAC_W-1:0] mac_pool [MAC_POOL_SIZE];

    int  failures   = 0;
    int  idle_count = 0;
    bit  src_taken  = 1'b0;   // set at the edge an item is accepted, cleared by the driver
    bit  holding    = 1'b0;   // driver has an item on the bus

    function automatic int fdb_find(logic [MAC_W-1:0] mac);
        for (int i = 0; i < FDB_DEPTH; i++)
            if (fdb_valid[i] && fdb_mac[i] == mac)
                return i;
        return -1;
    endfunction

    // first-seen learning into the lowest free slot, never moved afterwards
    function automatic void learn_source(input logic [MAC_W-1:0] mac, input logic [3:0] loc,
                                         output bit got, output bit full);
        got  = 1'b0;
        full = 1'b0;
        if (fdb_find(mac) >= 0)
            return;
        if (fdb_count >= FDB_DEPTH) begin
            full = 1'b1;
            return;
        end
        for (int i = 0; i < FDB_DEPTH; i++) begin
            if (!fdb_valid[i]) begin
                fdb_valid[i] = 1'b1;
                fdb_mac[i]   = mac;
                fdb_loc[i]   = loc;
                fdb_count++;
                got = 1'b1;
                return;
            end
        end
        full = 1'b1;
    endfunction

    // forwarding decision for one item, updating the mirror as the bridge would
    function automatic out_item_t forward_decision(in_item_t it);
        out_item_t res;
        bit        got;
        bit        full;
        int        s;
        int        d;
        bit        peer_ok;
        res        = '0;
        res.action = ACT_EVENT_DONE;
        got        = 1'b0;
        full       = 1'b0;
        peer_ok    = int'(it.peer_id) < PEER_COUNT;
        case (opcode_t'(it.opcode))
            OP_PEER_CONN: begin
                if (peer_ok)
                    peers_up[it.peer_id] = 1'b1;
            end
            OP_PEER_REMOVE: begin
                if (peer_ok)
                    peers_up[it.peer_id] = 1'b0;
            end
            OP_PEER_FRAME: begin
                // remote frames always go to the local net
                if (peer_ok)
                    learn_source(it.src_mac, 4'(it.peer_id), got, full);
                res.action = ACT_LOCAL_NET;
            end
            default: begin
                learn_source(it.src_mac, LOC_LOCAL, got, full);
                if (it.dst_mac == BCAST_MAC) begin
                    // flood to present peers, skipping the one that owns the source
                    res.action    = ACT_TO_PEERS;
                    res.peer_mask = peers_up;
                    s = fdb_find(it.src_mac);
                    if (s >= 0 && fdb_loc[s] < LOC_LOCAL)
                        res.peer_mask[fdb_loc[s][2:0]] = 1'b0;
                end else begin
                    d = fdb_find(it.dst_mac);
                    if (d < 0)
                        res.action = ACT_DROP_UNKNOWN;
                    else if (fdb_loc[d] >= LOC_LOCAL)
                        res.action = ACT_DROP_LOCAL;
                    else if (peers_up[fdb_loc[d][2:0]]) begin
                        res.action = ACT_TO_PEERS;
                        res.peer_mask = '0;
                        res.peer_mask[fdb_loc[d][2:0]] = 1'b1;
                    end else
                        res.action = ACT_DROP_ABSENT;   // stale peer, entry kept
                end
            end
        endcase
        res.learned    = got;
        res.table_full = full;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[MAC_W-1:0];
    endfunction

    function automatic in_item_t make_item(opcode_t op, logic [MAC_W-1:0] src,
                                           logic [MAC_W-1:0] dst, int peer);
        in_item_t it;
        it.opcode  = op;
        it.src_mac = src;
        it.dst_mac = dst;
        it.peer_id = PEER_ID_W'(peer);
        return it;
    endfunction

    function automatic logic [MAC_W-1:0] pool_or_fresh(int fresh_pct);
        if ($urandom_range(0, 99) < fresh_pct)
            return rand_mac();
        return mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
    endfunction

    // mostly well-formed traffic: frames between a bounded set of stations with
    // peers coming and going, plus some fully random items as noise
    function automatic in_item_t random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return make_item(opcode_t'($urandom_range(0, 3)), rand_mac(), rand_mac(),
                             $urandom_range(0, 7));
        if (pick < 13)
            return make_item(($urandom_range(0, 9) < 6) ? OP_PEER_CONN : OP_PEER_REMOVE,
                             rand_mac(), rand_mac(), $urandom_range(0, 7));
        if (pick < 40)
            return make_item(OP_PEER_FRAME, pool_or_fresh(15), pool_or_fresh(30),
                             $urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        return make_item(OP_LOCAL_FRAME, pool_or_fresh(12),
                         (pick < 30) ? BCAST_MAC : pool_or_fresh(pick < 85 ? 0 : 100),
                         $urandom_range(0, 7));
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (src_taken) begin
                src_taken = 1'b0;
                holding   = 1'b0;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (frames_to_send.size() > 0) begin
                    s_item  <= frames_to_send.pop_front();
                    s_valid <= 1'b1;
                    holding = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // a quarter of the bursts run straight into the next one
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: modes of always ready, random ready, and long stalls
    // ------------------------------------------------------------------
    int rdy_mode   = 0;
    int mode_left  = 0;
    int stall_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rdy_mode  = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (rdy_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 2) != 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            stall_left = $urandom_range(5, 25);
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on input accept, compare on result accept, watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                fwd_expect.push_back(forward_decision(s_item));
                src_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (fwd_expect.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_CAP)
                        $display("%0t: unexpected result item act=%0d mask=%02h lrn=%0b full=%0b",
                                 $time, m_item.action, m_item.peer_mask, m_item.learned,
                                 m_item.table_full);
                end else begin
                    want = fwd_expect.pop_front();
                    if (m_item.action !== want.action || m_item.peer_mask !== want.peer_mask
                        || m_item.learned !== want.learned
                        || m_item.table_full !== want.table_full) begin
                        failures++;
                        if (failures <= REPORT_CAP)
                            $display("%0t: mismatch exp act=%0d mask=%02h lrn=%0b full=%0b  got act=%0d mask=%02h lrn=%0b full=%0b",
                                     $time, want.action, want.peer_mask, want.learned,
                                     want.table_full, m_item.action, m_item.peer_mask,
                                     m_item.learned, m_item.table_full);
                    end
                end
            end
            // nothing moving on either channel counts toward the hang limit
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus build, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [MAC_W-1:0] sta_a;
        logic [MAC_W-1:0] sta_p0;
        logic [MAC_W-1:0] sta_p7;
        for (int i = 0; i < MAC_POOL_SIZE; i++)
            mac_pool[i] = rand_mac();
        sta_a  = 48'h02_00_00_00_00_0A;
        sta_p0 = 48'h02_00_00_00_01_00;
        sta_p7 = 48'h02_00_00_00_01_07;

        // broadcast with no peers present and an unlearned source
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, sta_a, BCAST_MAC, 0));
        // unknown unicast destination
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, sta_a, sta_p7, 5));
        frames_to_send.push_back(make_item(OP_PEER_CONN, '0, '0, 0));
        frames_to_send.push_back(make_item(OP_PEER_CONN, '1, '1, 7));
        frames_to_send.push_back(make_item(OP_PEER_FRAME, sta_p7, sta_a, 7));
        frames_to_send.push_back(make_item(OP_PEER_FRAME, sta_p0, BCAST_MAC, 0));
        // unicast to present peers
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, sta_a, sta_p7, 0));
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, sta_a, sta_p0, 7));
        // broadcast from a source held by a peer skips that peer
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, sta_p7, BCAST_MAC, 3));
        // unicast to a locally learned station
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, sta_p0, sta_a, 1));
        // remove twice, then stale-peer unicast
        frames_to_send.push_back(make_item(OP_PEER_REMOVE, '0, '0, 7));
        frames_to_send.push_back(make_item(OP_PEER_REMOVE, '1, '0, 7));
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, sta_a, sta_p7, 2));
        // repeated connect
        frames_to_send.push_back(make_item(OP_PEER_CONN, '0, '1, 3));
        frames_to_send.push_back(make_item(OP_PEER_CONN, '0, '1, 3));
        // known source seen from another peer stays where it was first learned
        frames_to_send.push_back(make_item(OP_PEER_FRAME, sta_p7, '0, 0));
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, sta_p7, BCAST_MAC, 6));
        // address extremes
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, '0, '0, 0));
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, '1, BCAST_MAC, 7));
        frames_to_send.push_back(make_item(OP_PEER_FRAME, '1, '1, 4));
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, sta_a, '1, 0));
        frames_to_send.push_back(make_item(OP_LOCAL_FRAME, '0, sta_a, 0));

        // random traffic; the table fills early, so table_full shows up often later
        for (int i = 0; i < RANDOM_ITEMS; i++)
            frames_to_send.push_back(random_item());

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every item accepted and every decision returned
        while (frames_to_send.size() != 0 || s_valid || fwd_expect.size() != 0)
            @(negedge aclk);
        // catch any stray result after the last one
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
